### rtl/ffsa_pkg.sv
// shared types and constants of the first-fit split allocator
// no dependencies
package ffsa_pkg;
  localparam int HeapBytes    = 65536;
  localparam int GranuleBytes = 32;
  localparam int HeaderBytes  = 16;
  localparam int NumGran      = HeapBytes / GranuleBytes;
  localparam int GranW        = $clog2(NumGran);
  localparam int SizeW        = 17;
  localparam int EntryW       = SizeW + 2;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusNoMem   = 2'd1;
  localparam logic [1:0] StatusBadAddr = 2'd2;

  localparam logic [1:0] RegLastFit = 2'd0;
  localparam logic [1:0] RegGuard   = 2'd1;
  localparam logic [1:0] RegMinSplit = 2'd2;

  typedef enum logic [3:0] {
    StIdle, StClear, StRead, StWait, StCheck, StSplitHi, StSplitLo,
    StFreeWait, StFreeDo, StDone
  } state_e;
endpackage

### rtl/ffsa_ram.sv
// generic single-port ram with registered read
// no dependencies
module ffsa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // read first port, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

### rtl/first_fit_split_allocator.sv
// top level of the first-fit split allocator
// depends on ffsa_pkg and ffsa_ram
//
// After reset the chunk table is cleared entry by entry (busy stays high);
// then one request is taken at a time. A free keeps busy high after its
// transfer through a wait state, a free state and the result state. An allocate
// walks the chunk table one chunk at a time (one ram read, its registered
// data, one compare), then writes a split as a high and a low entry and shows the
// result; a walk that starts past the heap end goes from the read state to the result. The
// result shows on the result ports for one cycle with done_o high and cannot be held off.
module first_fit_split_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        req_type_i,
  input  logic [15:0] alloc_size_i,
  input  logic [15:0] free_addr_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [15:0] payload_addr_o,
  output logic [16:0] granted_size_o,
  output logic [16:0] used_total_o,
  output logic [16:0] overhead_total_o
);
  import ffsa_pkg::*;

  // entry layout: {start, busy, size}
  state_e state_q, state_d;
  logic              last_fit_q;
  logic [8:0]        guard_q;
  logic [12:0]       min_split_q;
  logic [GranW:0]    clr_q;
  logic [GranW:0]    g_q;
  logic [GranW-1:0]  last_alloc_q;
  logic [GranW:0]    first_freed_q;
  logic [SizeW-1:0]  used_q, ovh_q;
  logic              type_q;
  logic [SizeW:0]    need_q;
  logic [15:0]       faddr_q;
  logic [GranW:0]    ng_q;
  logic [SizeW-1:0]  nsize_q, hsize_q;
  logic [1:0]        st_q;
  logic [15:0]       pay_q;
  logic [SizeW-1:0]  gsz_q;

  logic              we;
  logic [GranW-1:0]  addr;
  logic [EntryW-1:0] wdata, rdata;

  ffsa_ram #(.Width(EntryW), .Depth(NumGran)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  logic              e_start, e_busy;
  logic [SizeW-1:0]  e_size;
  assign e_start = rdata[EntryW-1];
  assign e_busy  = rdata[EntryW-2];
  assign e_size  = rdata[SizeW-1:0];

  // byte arithmetic of the current chunk
  logic [23:0] pay_b, endp, nextp_raw, nextp, nxt_b;
  logic [GranW+1:0] nxt_g;
  logic fit, do_split, bad_free;
  assign pay_b     = {{(23-GranW){1'b0}}, g_q} << 5;
  assign endp      = pay_b + 24'(e_size);
  assign nextp_raw = pay_b + 24'(need_q) + 24'(HeaderBytes) + 24'(GranuleBytes - 1);
  assign nextp     = {nextp_raw[23:5], 5'd0};
  assign nxt_b     = pay_b + 24'(e_size) + 24'(HeaderBytes);
  assign nxt_g     = (GranW + 2)'(nxt_b >> 5);
  assign fit       = !e_busy && ({1'b0, e_size} >= need_q);
  assign do_split  = (endp > nextp)
                   && ((endp - nextp) > 24'(min_split_q) + 24'(HeaderBytes))
                   && ((nextp >> 5) < 24'(NumGran));
  assign bad_free  = (faddr_q[4:0] != 5'd0) || (faddr_q[15:5] == '0)
                   || ((faddr_q >> 5) >= 16'(NumGran));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (start_i) state_d = req_type_i ? StFreeWait : StRead;
      StClear: if (clr_q == (GranW+1)'(NumGran - 1)) state_d = StIdle;
      StRead: state_d = (g_q >= (GranW+1)'(NumGran)) ? StDone : StWait;
      StWait: state_d = StCheck;
      StCheck: begin
        if (!e_start) state_d = StDone;
        else if (fit) state_d = do_split ? StSplitHi : StDone;
        else if (nxt_g <= {1'b0, g_q}) state_d = StDone;
        else state_d = StRead;
      end
      StSplitHi: state_d = StSplitLo;
      StSplitLo: state_d = StDone;
      StFreeWait: state_d = StFreeDo;
      StFreeDo: state_d = StDone;
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // ram port control
  always_comb begin
    we = 1'b0;
    addr = g_q[GranW-1:0];
    wdata = rdata;
    case (state_q)
      StClear: begin
        we = 1'b1;
        addr = clr_q[GranW-1:0];
        wdata = (clr_q == (GranW+1)'(1))
              ? {1'b1, 1'b0, SizeW'(HeapBytes - GranuleBytes)} : '0;
      end
      StIdle: addr = free_addr_i[GranW+4:5];
      StFreeWait: addr = faddr_q[GranW+4:5];
      StFreeDo: begin
        addr = faddr_q[GranW+4:5];
        we = !bad_free && e_start && e_busy;
        wdata = {1'b1, 1'b0, e_size};
      end
      StSplitHi: begin
        we = 1'b1;
        addr = ng_q[GranW-1:0];
        wdata = {1'b1, 1'b0, nsize_q};
      end
      StSplitLo: begin
        we = 1'b1;
        wdata = {1'b1, 1'b1, hsize_q};
      end
      StCheck: begin
        we = e_start && fit && !do_split;
        wdata = {1'b1, 1'b1, e_size};
      end
      default: ;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_fit_q <= 1'b1;
      guard_q <= '0;
      min_split_q <= 13'd32;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegLastFit: last_fit_q <= cfg_data_i[0];
        RegGuard: guard_q <= cfg_data_i[8:0];
        RegMinSplit: min_split_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      last_alloc_q <= GranW'(1);
      first_freed_q <= (GranW+1)'(NumGran);
      used_q <= '0;
      ovh_q <= '0;
      g_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        StClear: clr_q <= clr_q + 1'b1;
        StIdle: if (start_i) begin
          type_q <= req_type_i;
          faddr_q <= free_addr_i;
          need_q <= 18'(alloc_size_i) + 18'(guard_q);
          st_q <= StatusNoMem;
          pay_q <= '0;
          gsz_q <= '0;
          if (last_fit_q && first_freed_q < {1'b0, last_alloc_q}) g_q <= first_freed_q;
          else if (last_fit_q) g_q <= {1'b0, last_alloc_q};
          else g_q <= (GranW+1)'(1);
        end
        StCheck: if (e_start) begin
          if (fit) begin
            st_q <= StatusOk;
            pay_q <= pay_b[15:0];
            last_alloc_q <= g_q[GranW-1:0];
            if (do_split) begin
              ng_q <= (GranW+1)'(nextp >> 5);
              nsize_q <= SizeW'(endp - nextp);
              hsize_q <= SizeW'(nextp - 24'(HeaderBytes) - pay_b);
              gsz_q <= SizeW'(nextp - 24'(HeaderBytes) - pay_b);
              used_q <= used_q + SizeW'(nextp - 24'(HeaderBytes) - pay_b);
              ovh_q <= ovh_q + SizeW'(HeaderBytes);
            end else begin
              gsz_q <= e_size;
              used_q <= used_q + e_size;
            end
          end else begin
            g_q <= (nxt_g >= (GranW+2)'(NumGran)) ? (GranW+1)'(NumGran)
                                                  : nxt_g[GranW:0];
          end
        end
        StFreeDo: begin
          if (bad_free || !e_start) st_q <= StatusBadAddr;
          else begin
            st_q <= StatusOk;
            if (e_busy) begin
              if (last_fit_q) begin
                if (faddr_q[GranW+4:5] == last_alloc_q) last_alloc_q <= GranW'(1);
                if ({1'b0, faddr_q[GranW+4:5]} < first_freed_q)
                  first_freed_q <= {1'b0, faddr_q[GranW+4:5]};
              end
              used_q <= (used_q >= e_size) ? used_q - e_size : '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // outputs
  assign busy_o = (state_q != StIdle);
  assign done_o = (state_q == StDone);
  assign status_o = st_q;
  assign payload_addr_o = type_q ? 16'd0 : pay_q;
  assign granted_size_o = type_q ? '0 : gsz_q;
  assign used_total_o = used_q;
  assign overhead_total_o = ovh_q;
endmodule

### rtl/ffsa_checker.sv
// port-level checks of the first-fit split allocator
// depends on ffsa_pkg and the top level ports
module ffsa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [15:0] payload_addr_o,
  input logic [16:0] granted_size_o
);
  import ffsa_pkg::*;

  // a transfer starts work
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("start not taken");
  // results only while busy
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("done while idle");
  // done is a single cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  // failures carry no grant
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != StatusOk |-> payload_addr_o == '0 && granted_size_o == '0)
    else $error("grant on failure");
endmodule

bind first_fit_split_allocator ffsa_checker u_ffsa_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .status_o, .payload_addr_o,
  .granted_size_o
);

### tb/first_fit_split_allocator_tb.sv
// self-checking testbench of the first-fit split allocator
// depends on ffsa_pkg and the first_fit_split_allocator rtl
`timescale 1ns / 100ps

module first_fit_split_allocator_tb;
  import ffsa_pkg::*;

  localparam bit ReqAlloc = 1'b0;
  localparam bit ReqFree  = 1'b1;
  localparam int Mask17   = 'h1FFFF;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] addr;
    logic [16:0] gsize;
    logic [16:0] used;
    logic [16:0] ovh;
  } alloc_result_t;

  typedef struct packed {
    bit            kind;
    logic [15:0]   size;
    logic [15:0]   addr;
    bit            has_exp;
    alloc_result_t exp;
  } heap_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [12:0] cfg_data_i = '0;
  logic        req_type_i = 1'b0;
  logic [15:0] alloc_size_i = '0;
  logic [15:0] free_addr_i = '0;
  logic        busy_o, done_o;
  logic [1:0]  status_o;
  logic [15:0] payload_addr_o;
  logic [16:0] granted_size_o, used_total_o, overhead_total_o;

  first_fit_split_allocator dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .req_type_i, .alloc_size_i, .free_addr_i, .done_o, .status_o,
    .payload_addr_o, .granted_size_o, .used_total_o, .overhead_total_o
  );

  // heap mirror
  bit start_map [NumGran];
  int size_tab [NumGran];
  bit busy_map [NumGran];
  int last_alloc, first_freed, used_cnt, ovh_cnt;
  int lf_mode, guard, min_split;

  alloc_result_t pending_results [$];
  logic [15:0]   live_addrs [$];
  int            err_cnt = 0;

  function automatic alloc_result_t status_only(logic [1:0] st);
    alloc_result_t r;
    r = '0;
    r.status = st;
    r.used = used_cnt[16:0];
    r.ovh = ovh_cnt[16:0];
    return r;
  endfunction

  function automatic alloc_result_t model_alloc(int req);
    int need, g, hit, n, nxt, pay, nextp, endp, ng;
    alloc_result_t r;
    need = req + guard;
    g = 1;
    hit = NumGran;
    if (lf_mode != 0) begin
      g = last_alloc;
      if (first_freed < last_alloc) g = first_freed;
    end
    // first-fit walk in address order, no wrap
    for (n = 0; n < NumGran && g < NumGran; n++) begin
      if (!start_map[g]) break;
      if (!busy_map[g] && size_tab[g] >= need) begin
        hit = g;
        break;
      end
      nxt = (g * GranuleBytes + size_tab[g] + HeaderBytes) / GranuleBytes;
      if (nxt <= g) break;
      g = (nxt >= NumGran) ? NumGran : nxt;
    end
    if (hit >= NumGran) return status_only(StatusNoMem);
    pay = hit * GranuleBytes;
    nextp = pay + need + HeaderBytes;
    endp = pay + size_tab[hit];
    nextp = (nextp + GranuleBytes - 1) / GranuleBytes * GranuleBytes;
    // split off the aligned remainder when large enough
    if (endp > nextp && (endp - nextp) > min_split + HeaderBytes
        && nextp / GranuleBytes < NumGran) begin
      ng = nextp / GranuleBytes;
      start_map[ng] = 1'b1;
      busy_map[ng] = 1'b0;
      size_tab[ng] = endp - nextp;
      size_tab[hit] = nextp - HeaderBytes - pay;
      ovh_cnt = (ovh_cnt + HeaderBytes) & Mask17;
    end
    busy_map[hit] = 1'b1;
    used_cnt = (used_cnt + size_tab[hit]) & Mask17;
    last_alloc = hit;
    r = status_only(StatusOk);
    r.addr = pay[15:0];
    r.gsize = size_tab[hit][16:0];
    return r;
  endfunction

  function automatic alloc_result_t model_free(logic [15:0] addr);
    int g;
    g = addr / GranuleBytes;
    if (addr % GranuleBytes != 0 || g == 0 || g >= NumGran || !start_map[g])
      return status_only(StatusBadAddr);
    if (busy_map[g]) begin
      if (lf_mode != 0) begin
        if (g == last_alloc) last_alloc = 1;
        if (g < first_freed) first_freed = g;
      end
      busy_map[g] = 1'b0;
      used_cnt = (used_cnt >= size_tab[g]) ? used_cnt - size_tab[g] : 0;
    end
    return status_only(StatusOk);
  endfunction

  function automatic heap_req_t mk_req(bit kind, int val, bit has_exp = 0,
                                       logic [1:0] st = StatusOk, int a = 0,
                                       int gs = 0, int u = 0, int o = 0);
    heap_req_t t;
    t = '0;
    t.kind = kind;
    if (kind == ReqAlloc) t.size = val[15:0];
    else t.addr = val[15:0];
    t.has_exp = has_exp;
    t.exp = {st, a[15:0], gs[16:0], u[16:0], o[16:0]};
    return t;
  endfunction

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #200000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic check_field(string name, logic [16:0] exp_v, logic [16:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      err_cnt++;
    end
  endtask

  // result checker, results cannot be held off
  always @(posedge clk_i) begin
    alloc_result_t e;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d",
                 $time, status_o);
        err_cnt++;
      end else begin
        e = pending_results.pop_front();
        check_field("status", e.status, status_o);
        check_field("payload_addr", e.addr, payload_addr_o);
        check_field("granted_size", e.gsize, granted_size_o);
        check_field("used_total", e.used, used_total_o);
        check_field("overhead_total", e.ovh, overhead_total_o);
      end
    end
  end

  // drive one request and wait for its transfer
  task automatic issue(heap_req_t t);
    alloc_result_t r;
    start_i <= 1'b1;
    req_type_i <= t.kind;
    alloc_size_i <= t.size;
    free_addr_i <= t.addr;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (t.kind == ReqAlloc) r = model_alloc(t.size);
    else r = model_free(t.addr);
    if (r.status == StatusOk && t.kind == ReqAlloc) live_addrs.push_back(r.addr);
    pending_results.push_back(t.has_exp ? t.exp : r);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[12:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegLastFit: lf_mode = val & 1;
      RegGuard: guard = val & 'h1FF;
      default: min_split = val & 'h1FFF;
    endcase
    @(posedge clk_i);
  endtask

  function automatic heap_req_t random_req();
    int sel, idx;
    heap_req_t t;
    sel = $urandom_range(99);
    if (sel < 55) begin
      sel = $urandom_range(99);
      if (sel < 60) t = mk_req(ReqAlloc, $urandom_range(511));
      else if (sel < 90) t = mk_req(ReqAlloc, $urandom_range(4095, 512));
      else if (sel < 98) t = mk_req(ReqAlloc, $urandom_range(16383, 4096));
      else t = mk_req(ReqAlloc, $urandom_range(65535));
    end else begin
      sel = $urandom_range(99);
      if (sel < 75 && live_addrs.size() != 0) begin
        idx = $urandom_range(live_addrs.size() - 1);
        t = mk_req(ReqFree, live_addrs[idx]);
        live_addrs.delete(idx);
      end else if (sel < 88) begin
        t = mk_req(ReqFree, $urandom_range(NumGran - 1) * GranuleBytes);
      end else begin
        t = mk_req(ReqFree, $urandom_range(65535));
      end
    end
    return t;
  endfunction

  // stimulus
  initial begin
    heap_req_t dir_tab [$];
    int gap_pct [4];
    int p, i;

    // mirror reset state
    start_map[1] = 1'b1;
    size_tab[1] = HeapBytes - GranuleBytes;
    last_alloc = 1;
    first_freed = NumGran;
    used_cnt = 0;
    ovh_cnt = 0;
    lf_mode = 1;
    guard = 0;
    min_split = 32;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);

    // directed part at reset configuration
    dir_tab.push_back(mk_req(ReqAlloc, 65535, 1, StatusNoMem, 0, 0, 0, 0));
    dir_tab.push_back(mk_req(ReqAlloc, 0, 1, StatusOk, 32, 16, 16, 16));
    dir_tab.push_back(mk_req(ReqFree, 0, 1, StatusBadAddr, 0, 0, 16, 16));
    dir_tab.push_back(mk_req(ReqFree, 33, 1, StatusBadAddr, 0, 0, 16, 16));
    dir_tab.push_back(mk_req(ReqFree, 65504, 1, StatusBadAddr, 0, 0, 16, 16));
    dir_tab.push_back(mk_req(ReqFree, 32, 1, StatusOk, 0, 0, 0, 16));
    dir_tab.push_back(mk_req(ReqFree, 32, 1, StatusOk, 0, 0, 0, 16));
    dir_tab.push_back(mk_req(ReqAlloc, 16, 1, StatusOk, 32, 16, 16, 16));
    dir_tab.push_back(mk_req(ReqAlloc, 65504));
    dir_tab.push_back(mk_req(ReqAlloc, 65472));
    dir_tab.push_back(mk_req(ReqFree, 64));
    dir_tab.push_back(mk_req(ReqAlloc, 100));
    dir_tab.push_back(mk_req(ReqAlloc, 65535));
    dir_tab.push_back(mk_req(ReqFree, 65535));
    dir_tab.push_back(mk_req(ReqFree, 32768));
    dir_tab.push_back(mk_req(ReqFree, 32));
    dir_tab.push_back(mk_req(ReqAlloc, 48));
    foreach (dir_tab[k]) issue(dir_tab[k]);
    drain();

    // random phases with different settings and sender gaps
    gap_pct = '{0, 65, 0, 7};
    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin
          write_reg(RegLastFit, 0);
          write_reg(RegGuard, 256);
          write_reg(RegMinSplit, 4096);
        end
        1: begin
          write_reg(RegLastFit, 1);
          write_reg(RegGuard, 0);
          write_reg(RegMinSplit, 0);
        end
        default: begin
          write_reg(RegLastFit, $urandom_range(1));
          write_reg(RegGuard, $urandom_range(256));
          write_reg(RegMinSplit, $urandom_range(4096));
        end
      endcase
      for (i = 0; i < 420; i++) begin
        if ($urandom_range(99) < gap_pct[p]) begin
          start_i <= 1'b0;
          repeat ($urandom_range(6, 1)) @(posedge clk_i);
        end
        issue(random_req());
        // hold off once until everything is back
        if (p == 1 && i == 200) drain();
      end
      drain();
    end

    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

### first_fit_split_allocator.f
rtl/ffsa_pkg.sv
rtl/ffsa_ram.sv
rtl/first_fit_split_allocator.sv
rtl/ffsa_checker.sv
tb/first_fit_split_allocator_tb.sv
